@@ rtl/pwcr_pkg.sv @@
// ----------------------------------------------------------------------------
// pwcr_pkg
// Shared constants and types for the pulse width capture ring.
// ----------------------------------------------------------------------------
package pwcr_pkg;

  localparam int RING_DEPTH_DEFAULT = 32;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int TIMER_W     = 16;
  localparam int SLOT_W      = 5;
  localparam int LEN_W       = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_CAPTURE_ENABLE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RING_LENGTH    = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_WIDTH      = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_WIDTH_EXCL = 4'd3;

  localparam logic             CAPTURE_ENABLE_RESET = 1'b0;
  localparam logic [LEN_W-1:0] RING_LENGTH_RESET    = 6'd16;
  localparam logic [TIMER_W-1:0] MIN_WIDTH_RESET    = 16'd128;
  localparam logic [TIMER_W-1:0] MAX_WIDTH_RESET    = 16'h9696;

  localparam logic ACTION_CAPTURE = 1'b0;
  localparam logic ACTION_READ    = 1'b1;

  typedef struct packed {
    logic               pair_done;
    logic [TIMER_W-1:0] measured_width;
    logic               stored;
    logic [SLOT_W-1:0]  slot_written;
  } capture_result_t;

  typedef struct packed {
    logic               capture_enable;
    logic [LEN_W-1:0]   ring_length;
    logic [TIMER_W-1:0] min_width;
    logic [TIMER_W-1:0] max_width_excl;
  } capture_cfg_t;

endpackage

@@ rtl/pulse_width_capture_ring.sv @@
// ----------------------------------------------------------------------------
// pulse_width_capture_ring
// Pulse width measurement from timer captures, with a ring of stored widths.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle while the result register is free or being
// taken; a result transfers when out_ready is high. Items pass through an input
// register and then a result register (fed by the ring's registered read
// port). Capture items alternate between opening and closing
// an edge pair; a closed pair's width (second minus first, modulo 65536) is
// written to the ring when it lies in [min_width, max_width_excl). Read items
// return a ring slot; slots never written read as zero, tracked by one valid
// flop per slot cleared at reset, so no clearing pass is needed.
module pulse_width_capture_ring #(
  parameter int RING_DEPTH = pwcr_pkg::RING_DEPTH_DEFAULT,
  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pwcr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pwcr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [pwcr_pkg::TIMER_W-1:0]      capture_value,
  input  logic [pwcr_pkg::SLOT_W-1:0]       read_slot,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              pair_done,
  output logic [pwcr_pkg::TIMER_W-1:0]      measured_width,
  output logic                              stored,
  output logic [pwcr_pkg::SLOT_W-1:0]       slot_written,
  output logic [pwcr_pkg::TIMER_W-1:0]      read_value
);

  pwcr_pkg::capture_cfg_t    cfg;
  pwcr_pkg::capture_result_t cap_result;
  pwcr_pkg::capture_result_t res;

  logic                         advance;
  logic                         s1_valid;
  logic                         s1_action;
  logic [pwcr_pkg::TIMER_W-1:0] s1_capture;
  logic [pwcr_pkg::SLOT_W-1:0]  s1_slot;
  logic                         s2_read_hit;
  logic                         edge_event;
  logic                         slot_in_range;
  logic [AW-1:0]                rd_addr;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [pwcr_pkg::TIMER_W-1:0] wr_data;
  logic [pwcr_pkg::TIMER_W-1:0] rd_data;
  logic [RING_DEPTH-1:0]        slot_valid;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capture_enable <= pwcr_pkg::CAPTURE_ENABLE_RESET;
      cfg.ring_length    <= pwcr_pkg::RING_LENGTH_RESET;
      cfg.min_width      <= pwcr_pkg::MIN_WIDTH_RESET;
      cfg.max_width_excl <= pwcr_pkg::MAX_WIDTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pwcr_pkg::REG_CAPTURE_ENABLE: cfg.capture_enable <= cfg_data[0];
        pwcr_pkg::REG_RING_LENGTH:    cfg.ring_length <= cfg_data[pwcr_pkg::LEN_W-1:0];
        pwcr_pkg::REG_MIN_WIDTH:      cfg.min_width <= cfg_data;
        pwcr_pkg::REG_MAX_WIDTH_EXCL: cfg.max_width_excl <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline moves when the result register is free or being taken
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_action  <= action;
      s1_capture <= capture_value;
      s1_slot    <= read_slot;
    end
  end

  assign edge_event = s1_valid && advance && (s1_action == pwcr_pkg::ACTION_CAPTURE)
                      && cfg.capture_enable;

  pwcr_capture #(
    .RING_DEPTH (RING_DEPTH)
  ) u_capture (
    .clk           (clk),
    .rst           (rst),
    .edge_event    (edge_event),
    .capture_value (s1_capture),
    .cfg           (cfg),
    .result        (cap_result),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  assign slot_in_range = 32'(s1_slot) < 32'(RING_DEPTH);
  assign rd_addr       = AW'(s1_slot);

  pwcr_ram #(
    .WIDTH (pwcr_pkg::TIMER_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (advance),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en) begin
      slot_valid[wr_addr] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res         <= cap_result;
      s2_read_hit <= (s1_action == pwcr_pkg::ACTION_READ) && slot_in_range
                     && slot_valid[rd_addr];
    end
  end

  assign pair_done      = res.pair_done;
  assign measured_width = res.measured_width;
  assign stored         = res.stored;
  assign slot_written   = res.slot_written;
  assign read_value     = s2_read_hit ? rd_data : '0;

endmodule

@@ rtl/pwcr_ram.sv @@
// ----------------------------------------------------------------------------
// pwcr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pwcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/pwcr_capture.sv @@
// ----------------------------------------------------------------------------
// pwcr_capture
// Edge pairing, width computation, window check and ring write index.
// ----------------------------------------------------------------------------
module pwcr_capture #(
  parameter int RING_DEPTH = pwcr_pkg::RING_DEPTH_DEFAULT,
  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
  localparam int LW = $clog2(RING_DEPTH + 1),
  localparam int CW = (LW > pwcr_pkg::LEN_W) ? LW : pwcr_pkg::LEN_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           edge_event,
  input  logic [pwcr_pkg::TIMER_W-1:0]   capture_value,
  input  pwcr_pkg::capture_cfg_t         cfg,
  output pwcr_pkg::capture_result_t      result,
  output logic                           wr_en,
  output logic [AW-1:0]                  wr_addr,
  output logic [pwcr_pkg::TIMER_W-1:0]   wr_data
);

  logic                         awaiting_second_edge;
  logic [pwcr_pkg::TIMER_W-1:0] first_timestamp;
  logic [AW-1:0]                write_index;
  logic [AW-1:0]                write_index_next;

  logic [CW-1:0]                len_ext;
  logic [CW-1:0]                eff_len;
  logic [CW-1:0]                index_ext;
  logic [CW-1:0]                index_inc;
  logic [AW-1:0]                index_base;
  logic [pwcr_pkg::TIMER_W-1:0] width;
  logic                         in_window;
  logic                         close_pair;

  always_comb begin
    len_ext = CW'(cfg.ring_length);
    if (len_ext == '0) begin
      eff_len = CW'(1);
    end else if (len_ext > CW'(RING_DEPTH)) begin
      eff_len = CW'(RING_DEPTH);
    end else begin
      eff_len = len_ext;
    end
  end

  assign close_pair = edge_event && awaiting_second_edge;
  assign width      = capture_value - first_timestamp;
  assign in_window  = (width >= cfg.min_width) && (width < cfg.max_width_excl);

  always_comb begin
    index_ext  = CW'(write_index);
    index_base = (index_ext >= eff_len) ? '0 : write_index;
    index_inc  = CW'(index_base) + CW'(1);
    write_index_next = (index_inc >= eff_len) ? '0 : AW'(index_inc);
  end

  assign wr_en   = close_pair && in_window;
  assign wr_addr = index_base;
  assign wr_data = width;

  always_comb begin
    result = '0;
    if (close_pair) begin
      result.pair_done      = 1'b1;
      result.measured_width = width;
      if (in_window) begin
        result.stored       = 1'b1;
        result.slot_written = pwcr_pkg::SLOT_W'(index_base);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_second_edge <= 1'b0;
      first_timestamp      <= '0;
      write_index          <= '0;
    end else if (edge_event) begin
      awaiting_second_edge <= !awaiting_second_edge;
      if (!awaiting_second_edge) begin
        first_timestamp <= capture_value;
      end else begin
        write_index <= in_window ? write_index_next : index_base;
      end
    end
  end

endmodule

@@ dv/tb_pulse_width_capture_ring.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pulse_width_capture_ring
// Self-checking bench for the pulse width capture ring. A directed table of
// edge pairs, reads and register writes comes first, then phases of random
// edge pairs and reads under register settings fixed in the first two phases
// and random after. Both handshake sides idle at random, and every result is
// compared field by field with the table's expected value or a behavioral predictor of the capture logic.
// ----------------------------------------------------------------------------
module tb_pulse_width_capture_ring;

  localparam int CLK_PERIOD    = 20;
  localparam int DEPTH         = 32;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 80;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [pwcr_pkg::CFG_INDEX_W-1:0] REG_UNUSED_TOP = 4'hF;

  typedef struct packed {
    logic                         pair_done;
    logic [pwcr_pkg::TIMER_W-1:0] measured_width;
    logic                         stored;
    logic [pwcr_pkg::SLOT_W-1:0]  slot_written;
    logic [pwcr_pkg::TIMER_W-1:0] read_value;
  } width_report_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic                             act;
    logic [pwcr_pkg::TIMER_W-1:0]     cap;
    logic [pwcr_pkg::SLOT_W-1:0]      slot;
    logic [pwcr_pkg::CFG_INDEX_W-1:0] reg_idx;
    logic [pwcr_pkg::CFG_DATA_W-1:0]  reg_data;
    logic                             fixed;
    width_report_t                    want;
  } table_row_t;

  logic                             clk;
  logic                             rst;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [pwcr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [pwcr_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             in_valid;
  logic                             in_ready;
  logic                             action;
  logic [pwcr_pkg::TIMER_W-1:0]     capture_value;
  logic [pwcr_pkg::SLOT_W-1:0]      read_slot;
  logic                             out_valid;
  logic                             out_ready;
  logic                             pair_done;
  logic [pwcr_pkg::TIMER_W-1:0]     measured_width;
  logic                             stored;
  logic [pwcr_pkg::SLOT_W-1:0]      slot_written;
  logic [pwcr_pkg::TIMER_W-1:0]     read_value;

  // predictor state
  logic                         m_enable;
  logic [pwcr_pkg::LEN_W-1:0]   m_length;
  logic [pwcr_pkg::TIMER_W-1:0] m_min;
  logic [pwcr_pkg::TIMER_W-1:0] m_max;
  logic                         m_edge_open;
  logic [pwcr_pkg::TIMER_W-1:0] m_first_ts;
  logic [pwcr_pkg::SLOT_W-1:0]  m_wr_idx;
  logic [pwcr_pkg::TIMER_W-1:0] m_ring [DEPTH];

  width_report_t report_q[$];
  table_row_t    dir_rows[$];
  int            errors;
  bit            src_calm;
  bit            sink_calm;
  bit            hold_req;

  pulse_width_capture_ring #(
    .RING_DEPTH(DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .capture_value (capture_value),
    .read_slot     (read_slot),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pair_done     (pair_done),
    .measured_width(measured_width),
    .stored        (stored),
    .slot_written  (slot_written),
    .read_value    (read_value)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic width_report_t measure_step(logic act,
                                                 logic [pwcr_pkg::TIMER_W-1:0] cap,
                                                 logic [pwcr_pkg::SLOT_W-1:0] slot);
    width_report_t r;
    int            eff_len;
    r = '0;
    if (act == pwcr_pkg::ACTION_READ) begin
      r.read_value = m_ring[slot];
    end else if (m_enable) begin
      if (!m_edge_open) begin
        m_first_ts  = cap;
        m_edge_open = 1'b1;
      end else begin
        eff_len = (m_length == 0) ? 1 : (m_length > DEPTH) ? DEPTH : int'(m_length);
        m_edge_open      = 1'b0;
        r.pair_done      = 1'b1;
        r.measured_width = cap - m_first_ts;
        if (m_wr_idx >= eff_len) m_wr_idx = '0;
        if (r.measured_width >= m_min && r.measured_width < m_max) begin
          m_ring[m_wr_idx] = r.measured_width;
          r.stored         = 1'b1;
          r.slot_written   = m_wr_idx;
          m_wr_idx         = (m_wr_idx + 1 >= eff_len) ? '0 : m_wr_idx + 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // widths near the window edges, zero, all ones, or anywhere inside the window (any width if it is empty)
  function automatic logic [pwcr_pkg::TIMER_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return m_min;
      1:       return m_min - 1'b1;
      2:       return m_max;
      3:       return m_max - 1'b1;
      4:       return '0;
      5:       return '1;
      default: return (m_max > m_min) ?
                      pwcr_pkg::TIMER_W'($urandom_range(m_min, m_max - 1'b1)) :
                      pwcr_pkg::TIMER_W'($urandom);
    endcase
  endfunction

  function automatic void add_item(logic act, logic [pwcr_pkg::TIMER_W-1:0] cap,
                                   logic [pwcr_pkg::SLOT_W-1:0] slot);
    table_row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.act  = act;
    r.cap  = cap;
    r.slot = slot;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_fixed(logic act, logic [pwcr_pkg::TIMER_W-1:0] cap,
                                    logic [pwcr_pkg::SLOT_W-1:0] slot, width_report_t want);
    table_row_t r;
    r       = '0;
    r.kind  = ROW_ITEM;
    r.act   = act;
    r.cap   = cap;
    r.slot  = slot;
    r.fixed = 1'b1;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_reg(logic [pwcr_pkg::CFG_INDEX_W-1:0] idx,
                                  logic [pwcr_pkg::CFG_DATA_W-1:0] data);
    table_row_t r;
    r          = '0;
    r.kind     = ROW_REG;
    r.reg_idx  = idx;
    r.reg_data = data;
    dir_rows.push_back(r);
  endfunction

  task automatic send_item(logic act, logic [pwcr_pkg::TIMER_W-1:0] cap,
                           logic [pwcr_pkg::SLOT_W-1:0] slot,
                           logic fixed, width_report_t want);
    int            gap;
    width_report_t model;
    if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
    gap = pick_gap(src_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    capture_value <= cap;
    read_slot     <= slot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model = measure_step(act, cap, slot);
    report_q.push_back(fixed ? want : model);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [pwcr_pkg::CFG_INDEX_W-1:0] idx,
                           logic [pwcr_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pwcr_pkg::REG_CAPTURE_ENABLE: m_enable = data[0];
      pwcr_pkg::REG_RING_LENGTH:    m_length = data[pwcr_pkg::LEN_W-1:0];
      pwcr_pkg::REG_MIN_WIDTH:      m_min    = data;
      pwcr_pkg::REG_MAX_WIDTH_EXCL: m_max    = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    width_report_t got;
    width_report_t want;
    if (out_valid && out_ready) begin
      got = {pair_done, measured_width, stored, slot_written, read_value};
      if (report_q.size() == 0) begin
        $error("result transfer with nothing outstanding");
        errors++;
      end else begin
        want = report_q.pop_front();
        if (got.pair_done !== want.pair_done) begin
          $error("pair_done: expected %0d, got %0d", want.pair_done, got.pair_done);
          errors++;
        end
        if (got.measured_width !== want.measured_width) begin
          $error("measured_width: expected %0d, got %0d",
                 want.measured_width, got.measured_width);
          errors++;
        end
        if (got.stored !== want.stored) begin
          $error("stored: expected %0d, got %0d", want.stored, got.stored);
          errors++;
        end
        if (got.slot_written !== want.slot_written) begin
          $error("slot_written: expected %0d, got %0d", want.slot_written, got.slot_written);
          errors++;
        end
        if (got.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
          errors++;
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else begin
        stall = pick_gap(sink_calm);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("pulse_width_capture_ring test failed");
    $finish;
  end

  initial begin : stimulus
    table_row_t                   row;
    int                           i;
    int                           p;
    int                           n;
    int                           r;
    logic                         en;
    logic [pwcr_pkg::LEN_W-1:0]   len;
    logic [pwcr_pkg::TIMER_W-1:0] lo;
    logic [pwcr_pkg::TIMER_W-1:0] hi;
    logic [31:0]                  rnd;

    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    action        = pwcr_pkg::ACTION_CAPTURE;
    capture_value = '0;
    read_slot     = '0;
    errors        = 0;
    src_calm      = 1'b0;
    sink_calm     = 1'b0;
    hold_req      = 1'b0;
    m_enable      = pwcr_pkg::CAPTURE_ENABLE_RESET;
    m_length      = pwcr_pkg::RING_LENGTH_RESET;
    m_min         = pwcr_pkg::MIN_WIDTH_RESET;
    m_max         = pwcr_pkg::MAX_WIDTH_RESET;
    m_edge_open   = 1'b0;
    m_first_ts    = '0;
    m_wr_idx      = '0;
    for (i = 0; i < DEPTH; i++) m_ring[i] = '0;

    // capture off after reset, ring reads zero
    add_fixed(pwcr_pkg::ACTION_CAPTURE, 16'hFFFF, 5'd31, '0);
    add_fixed(pwcr_pkg::ACTION_READ,    16'h0000, 5'd0,  '0);
    add_reg(pwcr_pkg::REG_CAPTURE_ENABLE, 16'hFFFF);
    add_fixed(pwcr_pkg::ACTION_CAPTURE, 16'h0000, 5'd0, '0);
    add_fixed(pwcr_pkg::ACTION_CAPTURE, 16'hFFFF, 5'd0,
              {1'b1, 16'hFFFF, 1'b0, 5'd0, 16'h0000});
    // timer wrap within a pair
    add_fixed(pwcr_pkg::ACTION_CAPTURE, 16'hFFFF, 5'd0, '0);
    add_fixed(pwcr_pkg::ACTION_CAPTURE, 16'h0000, 5'd0,
              {1'b1, 16'h0001, 1'b0, 5'd0, 16'h0000});
    // equal timestamps
    add_fixed(pwcr_pkg::ACTION_CAPTURE, 16'h1234, 5'd0, '0);
    add_fixed(pwcr_pkg::ACTION_CAPTURE, 16'h1234, 5'd0,
              {1'b1, 16'h0000, 1'b0, 5'd0, 16'h0000});
    // window edges, min inside and max outside
    add_fixed(pwcr_pkg::ACTION_CAPTURE, 16'hFF80, 5'd0, '0);
    add_fixed(pwcr_pkg::ACTION_CAPTURE, 16'h0000, 5'd0,
              {1'b1, 16'h0080, 1'b1, 5'd0, 16'h0000});
    add_fixed(pwcr_pkg::ACTION_CAPTURE, 16'h0000, 5'd0, '0);
    add_fixed(pwcr_pkg::ACTION_CAPTURE, 16'h9695, 5'd0,
              {1'b1, 16'h9695, 1'b1, 5'd1, 16'h0000});
    add_fixed(pwcr_pkg::ACTION_CAPTURE, 16'h5555, 5'd0, '0);
    add_fixed(pwcr_pkg::ACTION_CAPTURE, 16'hEBEB, 5'd0,
              {1'b1, 16'h9696, 1'b0, 5'd0, 16'h0000});
    add_fixed(pwcr_pkg::ACTION_READ,    16'h0000, 5'd0,
              {1'b0, 16'h0000, 1'b0, 5'd0, 16'h0080});
    add_fixed(pwcr_pkg::ACTION_READ,    16'h0000, 5'd1,
              {1'b0, 16'h0000, 1'b0, 5'd0, 16'h9695});
    // one-slot ring with the write index already past it, window of all widths below 0xFFFF
    add_reg(pwcr_pkg::REG_RING_LENGTH, 16'h0001);
    add_reg(pwcr_pkg::REG_MIN_WIDTH, 16'h0000);
    add_reg(pwcr_pkg::REG_MAX_WIDTH_EXCL, 16'hFFFF);
    add_item(pwcr_pkg::ACTION_CAPTURE, 16'h0000, 5'd0);
    add_item(pwcr_pkg::ACTION_CAPTURE, 16'h0000, 5'd0);
    add_item(pwcr_pkg::ACTION_CAPTURE, 16'hAAAA, 5'd10);
    add_item(pwcr_pkg::ACTION_CAPTURE, 16'h5555, 5'd21);
    add_item(pwcr_pkg::ACTION_READ,    16'h0000, 5'd0);
    // zero length acts as one, oversize length saturates, unknown index ignored
    add_reg(pwcr_pkg::REG_RING_LENGTH, 16'hFFC0);
    add_item(pwcr_pkg::ACTION_CAPTURE, 16'h0001, 5'd0);
    add_item(pwcr_pkg::ACTION_CAPTURE, 16'hFFFE, 5'd0);
    add_reg(pwcr_pkg::REG_RING_LENGTH, 16'h003F);
    add_reg(REG_UNUSED_TOP, 16'hFFFF);
    add_item(pwcr_pkg::ACTION_CAPTURE, 16'h0100, 5'd0);
    add_item(pwcr_pkg::ACTION_CAPTURE, 16'h0200, 5'd0);
    add_item(pwcr_pkg::ACTION_READ,    16'h0000, 5'd1);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_REG) begin
        drain_results();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_item(row.act, row.cap, row.slot, row.fixed, row.want);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      en = (p < 2) ? 1'b1 : ($urandom_range(0, 5) != 0);
      case (p)
        0: begin
          len = 6'd32;
          lo  = '0;
          hi  = '1;
        end
        1: begin
          len = 6'd1;
          lo  = 16'hFFFE;
          hi  = 16'hFFFF;
        end
        default: begin
          case ($urandom_range(0, 5))
            0:       len = '0;
            1:       len = 6'd1;
            2:       len = 6'd32;
            3:       len = pwcr_pkg::LEN_W'($urandom_range(33, 63));
            default: len = pwcr_pkg::LEN_W'($urandom_range(2, 31));
          endcase
          case ($urandom_range(0, 4))
            0: begin
              lo = '0;
              hi = '1;
            end
            1: begin
              lo = pwcr_pkg::TIMER_W'($urandom);
              hi = '0;
            end
            2: begin
              lo = pwcr_pkg::MIN_WIDTH_RESET;
              hi = pwcr_pkg::MAX_WIDTH_RESET;
            end
            default: begin
              lo = pwcr_pkg::TIMER_W'($urandom_range(0, 4000));
              hi = lo + pwcr_pkg::TIMER_W'($urandom_range(1, 30000));
            end
          endcase
        end
      endcase
      rnd = $urandom;
      write_reg(pwcr_pkg::REG_CAPTURE_ENABLE, {rnd[15:1], en});
      write_reg(pwcr_pkg::REG_RING_LENGTH, {rnd[31:22], len});
      write_reg(pwcr_pkg::REG_MIN_WIDTH, lo);
      write_reg(pwcr_pkg::REG_MAX_WIDTH_EXCL, hi);
      if ($urandom_range(0, 1) != 0)
        write_reg(pwcr_pkg::CFG_INDEX_W'(pwcr_pkg::REG_MAX_WIDTH_EXCL
                                         + $urandom_range(1, 12)),
                  pwcr_pkg::CFG_DATA_W'($urandom));

      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while items keep coming
        if (p == 2 && n == 10) hold_req = 1'b1;
        if (p == 4 && n == PHASE_ITEMS / 2) drain_results();
        r = $urandom_range(0, 99);
        if (r < 20)
          send_item(pwcr_pkg::ACTION_READ, pwcr_pkg::TIMER_W'($urandom),
                    pwcr_pkg::SLOT_W'($urandom), 1'b0, '0);
        else if (r < 30 || !m_edge_open)
          send_item(pwcr_pkg::ACTION_CAPTURE, pwcr_pkg::TIMER_W'($urandom),
                    pwcr_pkg::SLOT_W'($urandom), 1'b0, '0);
        else
          send_item(pwcr_pkg::ACTION_CAPTURE, m_first_ts + pick_width(),
                    pwcr_pkg::SLOT_W'($urandom), 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("pulse_width_capture_ring test passed");
    else
      $display("pulse_width_capture_ring test failed");
    $finish;
  end

endmodule
